// File: rtl/core/rot_pkg.sv
// Shared types, widths and codes for the reference-counted open table.
package rot_pkg;

  // Fixed field widths of the request and response beats and the table count
  localparam int unsigned OP_BITS     = 1;
  localparam int unsigned SECTOR_BITS = 10;
  localparam int unsigned SLOT_BITS   = 4;
  localparam int unsigned STATUS_BITS = 2;
  localparam int unsigned COUNT_BITS  = 16;

  // Parameter defaults
  localparam int unsigned TABLE_ENTRIES_DEF = 16;
  localparam int unsigned KEY_BITS_DEF      = 10;

  // Operation codes
  localparam logic [OP_BITS-1:0] OP_OPEN  = 1'b0;
  localparam logic [OP_BITS-1:0] OP_CLOSE = 1'b1;

  // Status codes
  localparam logic [STATUS_BITS-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_NOT_OPEN = 2'd2;

  typedef struct packed {
    logic [OP_BITS-1:0]     operation;
    logic [SECTOR_BITS-1:0] sector;
    logic [SLOT_BITS-1:0]   slot;
  } rot_req_t;

  typedef struct packed {
    logic [SLOT_BITS-1:0]   result_slot;
    logic [STATUS_BITS-1:0] status;
    logic                   released;
  } rot_rsp_t;

  // Table write controls from the sequencer
  typedef struct packed {
    logic wr_key;
    logic wr_count;
    logic set_valid;
    logic clr_valid;
  } rot_wr_ctl_t;

endpackage

// File: rtl/core/rot_if.sv
// Request and response channel interfaces of the open table.
interface rot_req_if;
  import rot_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [OP_BITS-1:0]     operation;
  logic [SECTOR_BITS-1:0] sector;
  logic [SLOT_BITS-1:0]   slot;

  modport source (output valid, output operation, output sector, output slot, input ready);
  modport sink   (input valid, input operation, input sector, input slot, output ready);
endinterface

interface rot_rsp_if;
  import rot_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [SLOT_BITS-1:0]   result_slot;
  logic [STATUS_BITS-1:0] status;
  logic                   released;

  modport source (output valid, output result_slot, output status, output released,
                  input ready);
  modport sink   (input valid, input result_slot, input status, input released,
                  output ready);
endinterface

// File: rtl/core/rot_table.sv
// Entry storage: valid flops plus key and count memories with registered read.
module rot_table #(
  parameter int unsigned TABLE_ENTRIES = rot_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned KEY_BITS      = rot_pkg::KEY_BITS_DEF,
  parameter int unsigned IDX_W         = $clog2(TABLE_ENTRIES)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [IDX_W-1:0]                rd_addr,
  output logic [KEY_BITS-1:0]             rd_key,
  output logic [rot_pkg::COUNT_BITS-1:0]  rd_count,
  output logic [TABLE_ENTRIES-1:0]        valid_vec,
  input  rot_pkg::rot_wr_ctl_t            wr_ctl,
  input  logic [IDX_W-1:0]                wr_addr,
  input  logic [KEY_BITS-1:0]             wr_key,
  input  logic [rot_pkg::COUNT_BITS-1:0]  wr_count
);
  import rot_pkg::*;

  logic [KEY_BITS-1:0]      key_mem   [TABLE_ENTRIES];
  logic [COUNT_BITS-1:0]    count_mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid_r;

  assign valid_vec = valid_r;

  // Valid marks, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_ctl.set_valid) begin
      valid_r[wr_addr] <= 1'b1;
    end else if (wr_ctl.clr_valid) begin
      valid_r[wr_addr] <= 1'b0;
    end
  end

  // Key and count memories, one write and one registered read port each
  always_ff @(posedge clk) begin
    if (wr_ctl.wr_key) begin
      key_mem[wr_addr] <= wr_key;
    end
    if (wr_ctl.wr_count) begin
      count_mem[wr_addr] <= wr_count;
    end
    rd_key   <= key_mem[rd_addr];
    rd_count <= count_mem[rd_addr];
  end

endmodule

// File: rtl/core/rot_ctrl.sv
// Sequencer: scans the table one entry per cycle and applies open/close updates.
module rot_ctrl #(
  parameter int unsigned TABLE_ENTRIES = rot_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned KEY_BITS      = rot_pkg::KEY_BITS_DEF,
  parameter int unsigned IDX_W         = $clog2(TABLE_ENTRIES)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // request side
  input  logic                            req_valid,
  output logic                            req_ready,
  input  rot_pkg::rot_req_t               req,
  // result side
  input  logic                            res_free,
  output logic                            res_valid,
  output rot_pkg::rot_rsp_t               res,
  // table access
  output logic [IDX_W-1:0]                rd_addr,
  input  logic [KEY_BITS-1:0]             rd_key,
  input  logic [rot_pkg::COUNT_BITS-1:0]  rd_count,
  input  logic [TABLE_ENTRIES-1:0]        valid_vec,
  output rot_pkg::rot_wr_ctl_t            wr_ctl,
  output logic [IDX_W-1:0]                wr_addr,
  output logic [KEY_BITS-1:0]             wr_key,
  output logic [rot_pkg::COUNT_BITS-1:0]  wr_count
);
  import rot_pkg::*;

  localparam int unsigned CNT_W = IDX_W + 1;
  localparam int unsigned SXW   = IDX_W + SLOT_BITS;
  localparam int unsigned KXW   = KEY_BITS + SECTOR_BITS;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SCAN     = 3'd1;
  localparam logic [2:0] S_COMMIT   = 3'd2;
  localparam logic [2:0] S_CLOSE_RD = 3'd3;
  localparam logic [2:0] S_CLOSE_EV = 3'd4;
  localparam logic [2:0] S_DONE     = 3'd5;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

  logic [2:0]            state_r, state_nxt;
  logic [KEY_BITS-1:0]   key_r, key_nxt;
  logic [SLOT_BITS-1:0]  slot_raw_r, slot_raw_nxt;
  logic [IDX_W-1:0]      slot_idx_r, slot_idx_nxt;
  logic [CNT_W-1:0]      idx_r, idx_nxt;
  logic                  cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]      cmp_idx_r, cmp_idx_nxt;
  logic                  hit_found_r, hit_found_nxt;
  logic [IDX_W-1:0]      hit_idx_r, hit_idx_nxt;
  logic [COUNT_BITS-1:0] hit_count_r, hit_count_nxt;
  logic                  free_found_r, free_found_nxt;
  logic [IDX_W-1:0]      free_idx_r, free_idx_nxt;
  rot_rsp_t              res_r, res_nxt;

  // Request field widening
  logic [KXW-1:0]        sector_ext;
  logic [SXW-1:0]        slot_ext;
  logic [SXW-1:0]        hit_ext;
  logic [SXW-1:0]        free_ext;
  logic                  slot_in_range;

  assign sector_ext    = {{KEY_BITS{1'b0}}, req.sector};
  assign slot_ext      = {{IDX_W{1'b0}}, req.slot};
  assign slot_in_range = slot_ext < SXW'(TABLE_ENTRIES);
  assign hit_ext       = {{SLOT_BITS{1'b0}}, hit_idx_r};
  assign free_ext      = {{SLOT_BITS{1'b0}}, free_idx_r};

  assign req_ready = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE) && res_free;
  assign res       = res_r;

  // Sequencer next state
  always_comb begin
    state_nxt      = state_r;
    key_nxt        = key_r;
    slot_raw_nxt   = slot_raw_r;
    slot_idx_nxt   = slot_idx_r;
    idx_nxt        = idx_r;
    cmp_vld_nxt    = 1'b0;
    cmp_idx_nxt    = cmp_idx_r;
    hit_found_nxt  = hit_found_r;
    hit_idx_nxt    = hit_idx_r;
    hit_count_nxt  = hit_count_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    res_nxt        = res_r;
    rd_addr        = idx_r[IDX_W-1:0];
    wr_ctl         = '0;
    wr_addr        = hit_idx_r;
    wr_key         = key_r;
    wr_count       = COUNT_ONE;

    unique case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          key_nxt        = sector_ext[KEY_BITS-1:0];
          slot_raw_nxt   = req.slot;
          slot_idx_nxt   = slot_ext[IDX_W-1:0];
          idx_nxt        = '0;
          hit_found_nxt  = 1'b0;
          free_found_nxt = 1'b0;
          if (req.operation == OP_OPEN) begin
            state_nxt = S_SCAN;
          end else if (slot_in_range && valid_vec[slot_ext[IDX_W-1:0]]) begin
            state_nxt = S_CLOSE_RD;
          end else begin
            res_nxt.result_slot = req.slot;
            res_nxt.status      = ST_NOT_OPEN;
            res_nxt.released    = 1'b0;
            state_nxt           = S_DONE;
          end
        end
      end

      S_SCAN: begin
        // issue one read per cycle
        if (idx_r != CNT_W'(TABLE_ENTRIES)) begin
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = idx_r[IDX_W-1:0];
          idx_nxt     = idx_r + CNT_W'(1);
        end else begin
          state_nxt = S_COMMIT;
        end
        // compare the entry read last cycle
        if (cmp_vld_r) begin
          if (valid_vec[cmp_idx_r]) begin
            if (!hit_found_r && rd_key == key_r) begin
              hit_found_nxt = 1'b1;
              hit_idx_nxt   = cmp_idx_r;
              hit_count_nxt = rd_count;
            end
          end else if (!free_found_r) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = cmp_idx_r;
          end
        end
      end

      S_COMMIT: begin
        res_nxt.released = 1'b0;
        if (hit_found_r) begin
          wr_ctl.wr_count     = 1'b1;
          wr_addr             = hit_idx_r;
          wr_count            = (hit_count_r == COUNT_MAX) ? hit_count_r
                                                           : hit_count_r + COUNT_ONE;
          res_nxt.result_slot = hit_ext[SLOT_BITS-1:0];
          res_nxt.status      = ST_OK;
        end else if (free_found_r) begin
          wr_ctl.wr_key       = 1'b1;
          wr_ctl.wr_count     = 1'b1;
          wr_ctl.set_valid    = 1'b1;
          wr_addr             = free_idx_r;
          wr_count            = COUNT_ONE;
          res_nxt.result_slot = free_ext[SLOT_BITS-1:0];
          res_nxt.status      = ST_OK;
        end else begin
          res_nxt.result_slot = '0;
          res_nxt.status      = ST_FULL;
        end
        state_nxt = S_DONE;
      end

      S_CLOSE_RD: begin
        rd_addr   = slot_idx_r;
        state_nxt = S_CLOSE_EV;
      end

      S_CLOSE_EV: begin
        wr_addr             = slot_idx_r;
        res_nxt.result_slot = slot_raw_r;
        res_nxt.status      = ST_OK;
        if (rd_count <= COUNT_ONE) begin
          wr_ctl.clr_valid = 1'b1;
          res_nxt.released = 1'b1;
        end else begin
          wr_ctl.wr_count  = 1'b1;
          wr_count         = rd_count - COUNT_ONE;
          res_nxt.released = 1'b0;
        end
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (res_free) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cmp_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cmp_vld_r <= cmp_vld_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    key_r        <= key_nxt;
    slot_raw_r   <= slot_raw_nxt;
    slot_idx_r   <= slot_idx_nxt;
    idx_r        <= idx_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    hit_found_r  <= hit_found_nxt;
    hit_idx_r    <= hit_idx_nxt;
    hit_count_r  <= hit_count_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    res_r        <= res_nxt;
  end

endmodule

// File: rtl/core/refcounted_open_table_unit.sv
// Top level of the reference-counted open table: sequencer, storage, output register.
//
// Usage: requests arrive on in_req (operation, sector, slot), one beat per
// request. Open (operation 0) looks up the sector key in the table and returns
// the matching slot with its count raised (saturating), or allocates the
// lowest free slot with count 1; a full table returns status 1. Close
// (operation 1) lowers the count of an open slot and frees it at zero,
// flagging released; a free or out-of-range slot returns status 2.
// Every request yields exactly one beat on out_rsp.
// Flow: an open walks the table one entry per cycle through a single
// registered memory read port and one key comparator, then commits its
// update and result. A close of an open slot reads its count, then writes
// it back lowered or frees the slot; a free or out-of-range slot skips the read.
// in_req.ready is high only while the sequencer is idle; one request is
// in flight at a time.
// A result sits in the output register while the sequencer takes the next
// request; if out_rsp stays stalled, the following result waits in the
// sequencer and no further request is accepted until it drains.
// Reset (rst_n low, synchronous) marks all slots free and drops any result.
module refcounted_open_table_unit #(
  parameter int unsigned TABLE_ENTRIES = rot_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned KEY_BITS      = rot_pkg::KEY_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  rot_req_if.sink   in_req,
  rot_rsp_if.source out_rsp
);
  import rot_pkg::*;

  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);

  rot_req_t              req;
  rot_rsp_t              res;
  logic                  res_valid;
  logic                  res_free;
  logic                  req_ready;
  logic [IDX_W-1:0]      rd_addr;
  logic [KEY_BITS-1:0]   rd_key;
  logic [COUNT_BITS-1:0] rd_count;
  logic [TABLE_ENTRIES-1:0] valid_vec;
  rot_wr_ctl_t           wr_ctl;
  logic [IDX_W-1:0]      wr_addr;
  logic [KEY_BITS-1:0]   wr_key;
  logic [COUNT_BITS-1:0] wr_count;

  logic                  out_valid_r;
  rot_rsp_t              out_data_r;

  assign req.operation = in_req.operation;
  assign req.sector    = in_req.sector;
  assign req.slot      = in_req.slot;
  assign in_req.ready  = req_ready;

  rot_ctrl #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .KEY_BITS      (KEY_BITS),
    .IDX_W         (IDX_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_req.valid),
    .req_ready (req_ready),
    .req       (req),
    .res_free  (res_free),
    .res_valid (res_valid),
    .res       (res),
    .rd_addr   (rd_addr),
    .rd_key    (rd_key),
    .rd_count  (rd_count),
    .valid_vec (valid_vec),
    .wr_ctl    (wr_ctl),
    .wr_addr   (wr_addr),
    .wr_key    (wr_key),
    .wr_count  (wr_count)
  );

  rot_table #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .KEY_BITS      (KEY_BITS),
    .IDX_W         (IDX_W)
  ) u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_addr   (rd_addr),
    .rd_key    (rd_key),
    .rd_count  (rd_count),
    .valid_vec (valid_vec),
    .wr_ctl    (wr_ctl),
    .wr_addr   (wr_addr),
    .wr_key    (wr_key),
    .wr_count  (wr_count)
  );

  // Output register: free when empty or being taken this cycle
  assign res_free = !out_valid_r || out_rsp.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.result_slot = out_data_r.result_slot;
  assign out_rsp.status      = out_data_r.status;
  assign out_rsp.released    = out_data_r.released;

endmodule

// File: tb/rot_table_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the open table: keeps its own copy of the table, predicts and compares responses.
module rot_table_checker
  import rot_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  rot_req_if          req,
  rot_rsp_if          rsp,
  output int unsigned errors,
  output int unsigned pending
);

  localparam int unsigned ENTRIES = TABLE_ENTRIES_DEF;
  localparam int unsigned KEYW    = KEY_BITS_DEF;
  localparam logic [COUNT_BITS-1:0] COUNT_SAT = '1;

  // Shadow table
  logic                  slot_open [ENTRIES];
  logic [KEYW-1:0]       slot_key  [ENTRIES];
  logic [COUNT_BITS-1:0] slot_refs [ENTRIES];

  // Responses owed by the block, oldest first
  rot_rsp_t rsp_owed [$];

  // Apply one request to the shadow table and return the response it must produce
  function automatic rot_rsp_t apply_table_request(rot_req_t r);
    rot_rsp_t        res;
    int              hit;
    int              free_idx;
    logic [KEYW-1:0] k;
    res      = '0;
    hit      = -1;
    free_idx = -1;
    k        = r.sector[KEYW-1:0];
    if (r.operation == OP_OPEN) begin
      // lowest matching valid slot wins; lowest free slot for allocation
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot_open[i]) begin
          if (hit < 0 && slot_key[i] == k) hit = i;
        end else if (free_idx < 0) begin
          free_idx = i;
        end
      end
      if (hit >= 0) begin
        if (slot_refs[hit] != COUNT_SAT) slot_refs[hit] = slot_refs[hit] + 1'b1;
        res.result_slot = SLOT_BITS'(hit);
      end else if (free_idx >= 0) begin
        slot_open[free_idx] = 1'b1;
        slot_key[free_idx]  = k;
        slot_refs[free_idx] = COUNT_BITS'(1);
        res.result_slot     = SLOT_BITS'(free_idx);
      end else begin
        res.status = ST_FULL;
      end
    end else begin
      res.result_slot = r.slot;
      if (r.slot < ENTRIES && slot_open[r.slot]) begin
        if (slot_refs[r.slot] <= COUNT_BITS'(1)) begin
          slot_refs[r.slot] = '0;
          slot_open[r.slot] = 1'b0;
          res.released      = 1'b1;
        end else begin
          slot_refs[r.slot] = slot_refs[r.slot] - 1'b1;
        end
      end else begin
        res.status = ST_NOT_OPEN;
      end
    end
    return res;
  endfunction

  // Compare each response beat, then record each accepted request beat
  always @(posedge clk) begin
    rot_rsp_t want;
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) begin
        slot_open[i] = 1'b0;
        slot_key[i]  = '0;
        slot_refs[i] = '0;
      end
      rsp_owed.delete();
      errors = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (rsp_owed.size() == 0) begin
          errors++;
          $error("unexpected response beat: result_slot %0d status %0d released %0d",
                 rsp.result_slot, rsp.status, rsp.released);
        end else begin
          want = rsp_owed.pop_front();
          if (rsp.result_slot !== want.result_slot) begin
            errors++;
            $error("result_slot expected %0d actual %0d", want.result_slot, rsp.result_slot);
          end
          if (rsp.status !== want.status) begin
            errors++;
            $error("status expected %0d actual %0d", want.status, rsp.status);
          end
          if (rsp.released !== want.released) begin
            errors++;
            $error("released expected %0d actual %0d", want.released, rsp.released);
          end
        end
      end
      if (req.valid && req.ready) begin
        rsp_owed.push_back(apply_table_request({req.operation, req.sector, req.slot}));
      end
    end
    pending = rsp_owed.size();
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// Top of the open-table testbench: clock, reset, request and response drivers, watchdog, verdict.
module tb;
  import rot_pkg::*;

  localparam int unsigned RESET_CYCLES = 10;
  localparam int unsigned IDLE_PCT     = 16;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned STALL_LIMIT  = 3000;
  localparam int unsigned RANDOM_ITEMS = 910;
  localparam int unsigned POOL_KEYS    = 20;
  localparam int unsigned DRAIN_CYCLES = 40;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  bit calm;      // no idling on either side while set
  bit hold_go;   // asks the response side for its long hold-off

  int unsigned errors;
  int unsigned pending;
  int unsigned quiet_cycles;

  rot_req_if req_ch ();
  rot_rsp_if rsp_ch ();

  refcounted_open_table_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch),
    .out_rsp (rsp_ch)
  );

  rot_table_checker scoreboard (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .errors  (errors),
    .pending (pending)
  );

  always #6 clk = ~clk;

  // Offer one request beat, with optional idle cycles first; returns at the accepting edge
  task automatic send_req(input logic [OP_BITS-1:0] op, input logic [SECTOR_BITS-1:0] sec,
                          input logic [SLOT_BITS-1:0] sl);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.operation <= op;
    req_ch.sector    <= sec;
    req_ch.slot      <= sl;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // Request stimulus and verdict
  initial begin
    logic [SECTOR_BITS-1:0] key_pool [POOL_KEYS];
    logic [SECTOR_BITS-1:0] sec;
    req_ch.valid     <= 1'b0;
    req_ch.operation <= OP_OPEN;
    req_ch.sector    <= '0;
    req_ch.slot      <= '0;
    calm    = 1'b0;
    hold_go = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: close of a free slot, extreme keys, a hit, fill to full, release, reuse
    send_req(OP_CLOSE, 10'h3FF, 4'd0);
    send_req(OP_OPEN, 10'h000, 4'hF);
    send_req(OP_OPEN, 10'h3FF, 4'h0);
    send_req(OP_OPEN, 10'h000, 4'h0);
    for (int i = 2; i < 16; i++) send_req(OP_OPEN, SECTOR_BITS'(i * 67 + 1), SLOT_BITS'(i));
    send_req(OP_OPEN, 10'h2AA, 4'h5);     // table full
    send_req(OP_CLOSE, 10'h000, 4'd15);   // count 1 -> released
    send_req(OP_CLOSE, 10'h000, 4'd0);    // count 2 -> 1
    send_req(OP_CLOSE, 10'h3FF, 4'd0);    // released
    send_req(OP_OPEN, 10'h155, 4'hA);     // reuses lowest free slot

    // Random: opens from a small key pool so the table fills and hits, closes on any slot
    hold_go = 1'b1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 250 == 0) begin
        foreach (key_pool[j]) key_pool[j] = SECTOR_BITS'($urandom);
      end
      calm = (n >= 400 && n < 550);
      if ($urandom_range(0, 99) < 55) begin
        sec = ($urandom_range(0, 9) == 0) ? SECTOR_BITS'($urandom)
                                          : key_pool[$urandom_range(0, POOL_KEYS - 1)];
        send_req(OP_OPEN, sec, SLOT_BITS'($urandom));
      end else begin
        send_req(OP_CLOSE, SECTOR_BITS'($urandom), SLOT_BITS'($urandom));
      end
    end

    // Close sweep over every slot
    calm = 1'b1;
    for (int s = 0; s < 16; s++) send_req(OP_CLOSE, '0, SLOT_BITS'(s));
    req_ch.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Response side: random stalls, one long hold-off, no stalls while calm
  initial begin
    bit held;
    held = 1'b0;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_go && !held) begin
        held = 1'b1;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        rsp_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        @(posedge clk);
      end
    end
  end

  // Watchdog: cycles with no beat on either channel
  always @(posedge clk) begin
    if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
